// ===== sv/crde_pkg.sv =====
package crde_pkg;

    localparam int CHANNELS = 16;
    localparam int CNT_W    = 5;
    localparam int NSLOT    = 16;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

    localparam logic [7:0] OP_OFFSET  = 8'h05;
    localparam logic [7:0] OP_VOL_ABS = 8'h06;
    localparam logic [7:0] OP_PIT_ABS = 8'h07;
    localparam logic [7:0] OP_VOL_DEL = 8'h08;
    localparam logic [7:0] OP_SAMPLE  = 8'h09;
    localparam logic [7:0] OP_ECHO    = 8'h0a;
    localparam logic [7:0] OP_VOL_EQ  = 8'h0b;
    localparam logic [7:0] OP_PIT_LO  = 8'h0c;
    localparam logic [7:0] OP_PIT_HI  = 8'h0d;
    localparam logic [7:0] OP_KEY_OFF = 8'h0e;
    localparam logic [7:0] OP_RETRIG  = 8'h0f;
    localparam logic [7:0] BASE_LEFT  = 8'h18;
    localparam logic [7:0] BASE_RIGHT = 8'h28;
    localparam logic [7:0] BASE_BOTH  = 8'h38;
    localparam logic [7:0] BASE_PLO   = 8'h60;
    localparam logic [7:0] BASE_PHI   = 8'ha0;
    localparam logic [7:0] BASE_NARR  = 8'h80;

    // slots in ascending opcode order
    typedef enum logic [3:0] {
        SL_OFFSET, SL_VOL_ABS, SL_PIT_ABS, SL_VOL_DEL, SL_SAMPLE, SL_ECHO,
        SL_VOL_EQ, SL_PIT_LO, SL_PIT_HI, SL_KEY_OFF, SL_RETRIG, SL_LEFT,
        SL_RIGHT, SL_BOTH, SL_PLO, SL_PHI
    } crde_slot_t;

    typedef struct packed {
        logic [NSLOT-1:0] en;
        logic [31:0]      offset;
        logic [15:0]      vol_l;
        logic [15:0]      vol_r;
        logic [15:0]      pitch;
        logic [7:0]       vd_l;
        logic [7:0]       vd_r;
        logic [15:0]      smp;
        logic [7:0]       echo;
        logic [7:0]       veq;
        logic [7:0]       pnarrow;
        logic [7:0]       op_left;
        logic [7:0]       op_right;
        logic [7:0]       op_both;
        logic [7:0]       op_plo;
        logic [7:0]       op_phi;
    } crde_cmd_t;

    function automatic logic [7:0] offs8(input logic signed [16:0] x);
        offs8 = (x > 17'sd0) ? 8'(x - 17'sd1) : 8'(x);
    endfunction

    function automatic logic abs_le(input logic signed [16:0] x,
                                    input logic signed [16:0] c);
        abs_le = (x <= c) && (x >= -c);
    endfunction

    function automatic logic [2:0] slot_len(input crde_slot_t s);
        logic [2:0] n;
        unique case (s)
            SL_OFFSET, SL_VOL_ABS:                        n = 3'd5;
            SL_PIT_ABS, SL_VOL_DEL, SL_SAMPLE:            n = 3'd3;
            SL_ECHO, SL_VOL_EQ, SL_PIT_LO, SL_PIT_HI:     n = 3'd2;
            default:                                      n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] slot_byte(input crde_cmd_t c, input crde_slot_t s,
                                             input logic [2:0] i);
        logic [7:0] b [5];
        b[0] = 8'h00; b[1] = 8'h00; b[2] = 8'h00; b[3] = 8'h00; b[4] = 8'h00;
        unique case (s)
            SL_OFFSET: begin
                b[0] = OP_OFFSET; b[1] = c.offset[7:0]; b[2] = c.offset[15:8];
                b[3] = c.offset[23:16]; b[4] = c.offset[31:24];
            end
            SL_VOL_ABS: begin
                b[0] = OP_VOL_ABS; b[1] = c.vol_l[7:0]; b[2] = c.vol_l[15:8];
                b[3] = c.vol_r[7:0]; b[4] = c.vol_r[15:8];
            end
            SL_PIT_ABS: begin
                b[0] = OP_PIT_ABS; b[1] = c.pitch[7:0]; b[2] = c.pitch[15:8];
            end
            SL_VOL_DEL: begin
                b[0] = OP_VOL_DEL; b[1] = c.vd_l; b[2] = c.vd_r;
            end
            SL_SAMPLE: begin
                b[0] = OP_SAMPLE; b[1] = c.smp[7:0]; b[2] = c.smp[15:8];
            end
            SL_ECHO: begin
                b[0] = OP_ECHO; b[1] = c.echo;
            end
            SL_VOL_EQ: begin
                b[0] = OP_VOL_EQ; b[1] = c.veq;
            end
            SL_PIT_LO: begin
                b[0] = OP_PIT_LO; b[1] = c.pnarrow;
            end
            SL_PIT_HI: begin
                b[0] = OP_PIT_HI; b[1] = c.pnarrow;
            end
            SL_KEY_OFF: b[0] = OP_KEY_OFF;
            SL_RETRIG:  b[0] = OP_RETRIG;
            SL_LEFT:    b[0] = c.op_left;
            SL_RIGHT:   b[0] = c.op_right;
            SL_BOTH:    b[0] = c.op_both;
            SL_PLO:     b[0] = c.op_plo;
            SL_PHI:     b[0] = c.op_phi;
            default:    b[0] = 8'h00;
        endcase
        return (i <= 3'd4) ? b[i] : 8'h00;
    endfunction

endpackage

// ===== sv/crde_front.sv =====
module crde_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [4:0]               cfg_wdata,
    input  logic                     accept,
    input  logic [3:0]               channel,
    input  logic                     invalidate,
    input  logic [5:0]               update_mask,
    input  logic [15:0]              pitch,
    input  logic [7:0]               echo,
    input  logic [15:0]              vol_left,
    input  logic [15:0]              vol_right,
    input  logic [15:0]              sample_number,
    input  logic [31:0]              sample_offset,
    output logic                     in_use,
    output logic                     push,
    output crde_pkg::crde_cmd_t      cmd
);

    logic [crde_pkg::CNT_W-1:0] count_reg;
    logic [15:0] pitch_reg  [crde_pkg::CHANNELS];
    logic [15:0] vl_reg     [crde_pkg::CHANNELS];
    logic [15:0] vr_reg     [crde_pkg::CHANNELS];
    logic [15:0] smp_reg    [crde_pkg::CHANNELS];
    logic [7:0]  echo_reg   [crde_pkg::CHANNELS];
    logic [crde_pkg::CHANNELS-1:0] sv_reg, ev_reg, fp_reg, fv_reg;

    logic [15:0] lp, lvl, lvr;
    logic fp, fv, sv, ev;
    logic do_p, do_e, do_v, has_v;
    logic [15:0] vl_e, vr_e;
    logic signed [16:0] p_dt, pdl, pdh, vdl, vdr;
    logic [7:0] p_l8;
    logic p_adj, small_p;
    logic signed [8:0] p_dl9;
    logic signed [7:0] p_dh8;
    logic [crde_pkg::NSLOT-1:0] en;

    assign lp  = pitch_reg[channel];
    assign lvl = vl_reg[channel];
    assign lvr = vr_reg[channel];
    assign fp  = invalidate | fp_reg[channel];
    assign fv  = invalidate | fv_reg[channel];
    assign sv  = ~invalidate & sv_reg[channel];
    assign ev  = ~invalidate & ev_reg[channel];
    assign in_use = {1'b0, channel} < count_reg;

    always_comb begin
        en  = '0;
        cmd = '0;
        // pitch
        p_dt    = $signed({1'b0, pitch}) - $signed({1'b0, lp});
        p_l8    = p_dt[7:0];
        p_adj   = p_dt[16] ? (p_l8 >= 8'h80) : (p_l8 > 8'h80);
        p_dl9   = $signed({p_adj, p_l8});
        p_dh8   = $signed(p_dt[15:8] + {7'd0, p_adj});
        pdl     = 17'(p_dl9);
        pdh     = 17'(p_dh8);
        small_p = crde_pkg::abs_le(pdl, 17'sd32) && crde_pkg::abs_le(pdh, 17'sd32) && !fp;
        do_p    = update_mask[0] && ((pitch != lp) || fp);
        cmd.pitch  = pitch;
        cmd.op_plo = crde_pkg::BASE_PLO + crde_pkg::offs8(pdl);
        cmd.op_phi = crde_pkg::BASE_PHI + crde_pkg::offs8(pdh);
        if (do_p) begin
            if (small_p) begin
                en[crde_pkg::SL_PLO] = (pdl != 17'sd0);
                en[crde_pkg::SL_PHI] = (pdh != 17'sd0);
            end else if ((pdl != 17'sd0 && pdh != 17'sd0) || fp) begin
                en[crde_pkg::SL_PIT_ABS] = 1'b1;
            end else if (pdh == 17'sd0) begin
                en[crde_pkg::SL_PIT_LO] = 1'b1;
            end else begin
                en[crde_pkg::SL_PIT_HI] = 1'b1;
            end
        end
        cmd.pnarrow = crde_pkg::BASE_NARR +
                      crde_pkg::offs8((pdh == 17'sd0) ? pdl : pdh);
        // echo
        do_e = update_mask[1] && (!ev || echo != echo_reg[channel]);
        en[crde_pkg::SL_ECHO] = do_e;
        cmd.echo = echo;
        // volume
        has_v = update_mask[2] | update_mask[3];
        vl_e  = update_mask[2] ? vol_left  : lvl;
        vr_e  = update_mask[3] ? vol_right : lvr;
        vdl   = $signed({1'b0, vl_e}) - $signed({1'b0, lvl});
        vdr   = $signed({1'b0, vr_e}) - $signed({1'b0, lvr});
        do_v  = has_v && (vdl != 17'sd0 || vdr != 17'sd0 || fv);
        cmd.vol_l    = vl_e;
        cmd.vol_r    = vr_e;
        cmd.vd_l     = crde_pkg::offs8(vdl);
        cmd.vd_r     = crde_pkg::offs8(vdr);
        cmd.veq      = crde_pkg::offs8(vdl);
        cmd.op_both  = crde_pkg::BASE_BOTH  + crde_pkg::offs8(vdl);
        cmd.op_left  = crde_pkg::BASE_LEFT  + crde_pkg::offs8(vdl);
        cmd.op_right = crde_pkg::BASE_RIGHT + crde_pkg::offs8(vdr);
        if (do_v) begin
            if (vl_e == 16'd0 && vr_e == 16'd0) begin
                en[crde_pkg::SL_KEY_OFF] = 1'b1;
            end else if (crde_pkg::abs_le(vdl, 17'sd128) &&
                         crde_pkg::abs_le(vdr, 17'sd128) && !fv) begin
                if (vdl == vdr) begin
                    if (crde_pkg::abs_le(vdl, 17'sd8)) en[crde_pkg::SL_BOTH] = 1'b1;
                    else                               en[crde_pkg::SL_VOL_EQ] = 1'b1;
                end else if (crde_pkg::abs_le(vdl, 17'sd8) &&
                             crde_pkg::abs_le(vdr, 17'sd8)) begin
                    en[crde_pkg::SL_LEFT]  = (vdl != 17'sd0);
                    en[crde_pkg::SL_RIGHT] = (vdr != 17'sd0);
                end else begin
                    en[crde_pkg::SL_VOL_DEL] = 1'b1;
                end
            end else begin
                en[crde_pkg::SL_VOL_ABS] = 1'b1;
            end
        end
        // sample and offset
        cmd.smp = sample_number;
        if (update_mask[4]) begin
            if (sv && sample_number == smp_reg[channel]) begin
                en[crde_pkg::SL_RETRIG] = !update_mask[5];
            end else begin
                en[crde_pkg::SL_SAMPLE] = 1'b1;
            end
        end
        en[crde_pkg::SL_OFFSET] = update_mask[5];
        cmd.offset = sample_offset;
        cmd.en     = en;
    end

    assign push = accept && in_use && (en != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= crde_pkg::CNT_RESET;
            for (int i = 0; i < crde_pkg::CHANNELS; i++) begin
                pitch_reg[i] <= '0;
                vl_reg[i]    <= '0;
                vr_reg[i]    <= '0;
                smp_reg[i]   <= '0;
                echo_reg[i]  <= '0;
            end
            sv_reg <= '1;
            ev_reg <= '1;
            fp_reg <= '0;
            fv_reg <= '0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            if (accept && in_use) begin
                fp_reg[channel] <= fp & ~do_p;
                fv_reg[channel] <= fv & ~do_v;
                sv_reg[channel] <= sv | update_mask[4];
                ev_reg[channel] <= ev | update_mask[1];
                if (do_p) begin
                    pitch_reg[channel] <= pitch;
                end
                if (update_mask[1]) begin
                    echo_reg[channel] <= echo;
                end
                if (do_v) begin
                    vl_reg[channel] <= vl_e;
                    vr_reg[channel] <= vr_e;
                end
                if (update_mask[4]) begin
                    smp_reg[channel] <= sample_number;
                end
            end
        end
    end

endmodule

// ===== sv/crde_fifo.sv =====
module crde_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  crde_pkg::crde_cmd_t wr_data,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output crde_pkg::crde_cmd_t rd_data
);

    crde_pkg::crde_cmd_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = count_reg == 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/crde_back.sv =====
module crde_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                hd_valid,
    input  crde_pkg::crde_cmd_t hd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_cmd_byte,
    output logic                m_cmd_start,
    output logic                m_last_byte
);

    logic [crde_pkg::NSLOT-1:0] done_reg, rem, cur_oh;
    logic [2:0] idx_reg;
    crde_pkg::crde_slot_t cur;
    logic emit, slot_end, item_end;
    logic valid_reg, start_reg, last_reg;
    logic [7:0] byte_reg;

    assign rem = hd.en & ~done_reg;

    always_comb begin
        cur = crde_pkg::SL_OFFSET;
        for (int i = crde_pkg::NSLOT - 1; i >= 0; i--) begin
            if (rem[i]) cur = crde_pkg::crde_slot_t'(4'(i));
        end
        cur_oh = '0;
        cur_oh[cur] = 1'b1;
    end

    assign emit     = hd_valid && (!valid_reg || m_ready);
    assign slot_end = idx_reg == crde_pkg::slot_len(cur) - 3'd1;
    assign item_end = slot_end && ((rem & ~cur_oh) == '0);
    assign pop      = emit && item_end;

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg  <= crde_pkg::slot_byte(hd, cur, idx_reg);
            start_reg <= idx_reg == 3'd0;
            last_reg  <= item_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (emit) begin
                if (item_end) begin
                    done_reg <= '0;
                    idx_reg  <= '0;
                end else if (slot_end) begin
                    done_reg <= done_reg | cur_oh;
                    idx_reg  <= '0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    assign m_valid     = valid_reg;
    assign m_cmd_byte  = byte_reg;
    assign m_cmd_start = start_reg;
    assign m_last_byte = last_reg;

endmodule

// ===== sv/channel_register_delta_encoder.sv =====
// channel register delta encoder
// input channel (s_valid/s_ready): one word of register updates for one
// channel per transfer; channels at or above the programmed count are taken
// and dropped. result channel (m_valid/m_ready): the command stream, one
// byte per transfer, m_cmd_start on each opcode, m_last_byte on the final
// byte of an input word. words that yield no command give no output.
// cfg_we/cfg_wdata write the channel count; the user must write it only while
// the block is idle, as the block does not enforce this. a word is classified
// and the channel history updated in the cycle it is taken; it then waits in
// a two-entry command queue. the byte serialiser sends one byte per cycle while
// the receiver is ready; a word has 1 to 18 bytes. s_ready only drops while
// the queue is full, so short words stream at one per cycle while the receiver
// keeps up. a stalled receiver holds the output register and fills the queue.
// reset clears the queue, sets the count to 16 and the history to zero.
module channel_register_delta_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_channel,
    input  logic        s_invalidate,
    input  logic [5:0]  s_update_mask,
    input  logic [15:0] s_pitch,
    input  logic [7:0]  s_echo,
    input  logic [15:0] s_vol_left,
    input  logic [15:0] s_vol_right,
    input  logic [15:0] s_sample_number,
    input  logic [31:0] s_sample_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_cmd_byte,
    output logic        m_cmd_start,
    output logic        m_last_byte
);

    crde_pkg::crde_cmd_t cmd, hd;
    logic push, full, pop, hd_valid, in_use, accept;

    assign s_ready = ~full;
    assign accept  = s_valid & s_ready;

    crde_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .accept,
        .channel(s_channel), .invalidate(s_invalidate), .update_mask(s_update_mask),
        .pitch(s_pitch), .echo(s_echo), .vol_left(s_vol_left),
        .vol_right(s_vol_right), .sample_number(s_sample_number),
        .sample_offset(s_sample_offset), .in_use, .push, .cmd
    );

    crde_fifo u_fifo (
        .aclk, .aresetn, .push, .wr_data(cmd), .full, .pop,
        .rd_valid(hd_valid), .rd_data(hd)
    );

    crde_back u_back (
        .aclk, .aresetn, .hd_valid, .hd, .pop, .m_valid, .m_ready,
        .m_cmd_byte, .m_cmd_start, .m_last_byte
    );

    a_drop_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !in_use |-> !push)
        else $error("dropped word entered the queue");

    a_opcode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cmd_start |-> m_cmd_byte >= crde_pkg::OP_OFFSET)
        else $error("opcode below command range");

    a_pop_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> hd_valid && hd.en != '0)
        else $error("queue popped without a pending word");

endmodule

// ===== tb/sv/crde_checker.sv =====
`timescale 1ns / 100ps

module crde_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [3:0]  s_channel,
    input  logic        s_invalidate,
    input  logic [5:0]  s_update_mask,
    input  logic [15:0] s_pitch,
    input  logic [7:0]  s_echo,
    input  logic [15:0] s_vol_left,
    input  logic [15:0] s_vol_right,
    input  logic [15:0] s_sample_number,
    input  logic [31:0] s_sample_offset,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_cmd_byte,
    input  logic        m_cmd_start,
    input  logic        m_last_byte,
    output int          fail_count,
    output int          pending_bytes
);

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       last;
    } cmd_byte_t;

    typedef struct {
        int         len;
        logic [7:0] b [5];
    } command_t;

    cmd_byte_t  byte_queue [$];
    logic [15:0] hist_pitch  [crde_pkg::CHANNELS];
    logic [15:0] hist_vol_l  [crde_pkg::CHANNELS];
    logic [15:0] hist_vol_r  [crde_pkg::CHANNELS];
    logic [15:0] hist_sample [crde_pkg::CHANNELS];
    logic        sample_known [crde_pkg::CHANNELS];
    logic [7:0]  hist_echo   [crde_pkg::CHANNELS];
    logic        echo_known  [crde_pkg::CHANNELS];
    logic        force_pitch [crde_pkg::CHANNELS];
    logic        force_vol   [crde_pkg::CHANNELS];
    logic [4:0]  chan_count;
    command_t    cmd_list [$];

    assign pending_bytes = byte_queue.size();

    function automatic int mag(int x);
        return x < 0 ? -x : x;
    endfunction

    function automatic int bias(int x);
        return x > 0 ? x - 1 : x;
    endfunction

    task automatic add_cmd(int n, logic [7:0] a, logic [7:0] b1 = 0, logic [7:0] c = 0,
                           logic [7:0] d = 0, logic [7:0] e = 0);
        command_t c0;
        c0.len = n;
        c0.b[0] = a; c0.b[1] = b1; c0.b[2] = c; c0.b[3] = d; c0.b[4] = e;
        cmd_list.insert(cmd_list.size(), c0);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic encode_word();
        int ch, pt, vl, vr, dt, dl, dh, dvl, dvr, n;
        logic [5:0] mask;
        cmd_byte_t cb;
        command_t tmp;
        ch = s_channel;
        mask = s_update_mask;
        if (ch >= chan_count || ch >= crde_pkg::CHANNELS) return;
        cmd_list.delete();
        if (s_invalidate) begin
            force_pitch[ch] = 1; force_vol[ch] = 1;
            sample_known[ch] = 0; echo_known[ch] = 0;
        end
        pt = s_pitch;
        if (mask[0] && (pt != hist_pitch[ch] || force_pitch[ch])) begin
            dt = pt - int'(hist_pitch[ch]);
            dl = dt & 'hff;
            dh = (dt >>> 8) & 'hff;
            if ((dt >= 0 && dl > 'h80) || (dt < 0 && dl >= 'h80)) begin
                dl -= 'h100; dh++;
            end
            if (dh >= 'h80) dh -= 'h100;
            if (mag(dl) <= 'h20 && mag(dh) <= 'h20 && !force_pitch[ch]) begin
                if (dl != 0) add_cmd(1, 8'(int'(crde_pkg::BASE_PLO) + bias(dl)));
                if (dh != 0) add_cmd(1, 8'(int'(crde_pkg::BASE_PHI) + bias(dh)));
            end else if ((dl != 0 && dh != 0) || force_pitch[ch]) begin
                add_cmd(3, crde_pkg::OP_PIT_ABS, pt[7:0], pt[15:8]);
            end else if (dh == 0) begin
                add_cmd(2, crde_pkg::OP_PIT_LO, 8'(int'(crde_pkg::BASE_NARR) + bias(dl)));
            end else begin
                add_cmd(2, crde_pkg::OP_PIT_HI, 8'(int'(crde_pkg::BASE_NARR) + bias(dh)));
            end
            hist_pitch[ch] = pt[15:0];
            force_pitch[ch] = 0;
        end
        if (mask[1] && (!echo_known[ch] || s_echo != hist_echo[ch])) begin
            add_cmd(2, crde_pkg::OP_ECHO, s_echo);
            hist_echo[ch] = s_echo; echo_known[ch] = 1;
        end
        if (mask[3:2] != 0) begin
            vl = mask[2] ? int'(s_vol_left) : int'(hist_vol_l[ch]);
            vr = mask[3] ? int'(s_vol_right) : int'(hist_vol_r[ch]);
            dvl = vl - int'(hist_vol_l[ch]);
            dvr = vr - int'(hist_vol_r[ch]);
            if (dvl != 0 || dvr != 0 || force_vol[ch]) begin
                if (vl == 0 && vr == 0) begin
                    add_cmd(1, crde_pkg::OP_KEY_OFF);
                end else if (mag(dvl) <= 'h80 && mag(dvr) <= 'h80 && !force_vol[ch]) begin
                    if (dvl == dvr) begin
                        if (mag(dvl) <= 8)
                            add_cmd(1, 8'(int'(crde_pkg::BASE_BOTH) + bias(dvl)));
                        else add_cmd(2, crde_pkg::OP_VOL_EQ, 8'(bias(dvl)));
                    end else if (mag(dvl) <= 8 && mag(dvr) <= 8) begin
                        if (dvl != 0)
                            add_cmd(1, 8'(int'(crde_pkg::BASE_LEFT) + bias(dvl)));
                        if (dvr != 0)
                            add_cmd(1, 8'(int'(crde_pkg::BASE_RIGHT) + bias(dvr)));
                    end else begin
                        add_cmd(3, crde_pkg::OP_VOL_DEL, 8'(bias(dvl)), 8'(bias(dvr)));
                    end
                end else begin
                    add_cmd(5, crde_pkg::OP_VOL_ABS, vl[7:0], vl[15:8], vr[7:0], vr[15:8]);
                end
                hist_vol_l[ch] = vl[15:0];
                hist_vol_r[ch] = vr[15:0];
                force_vol[ch] = 0;
            end
        end
        if (mask[4]) begin
            if (sample_known[ch] && s_sample_number == hist_sample[ch]) begin
                if (!mask[5]) add_cmd(1, crde_pkg::OP_RETRIG);
            end else begin
                add_cmd(3, crde_pkg::OP_SAMPLE, s_sample_number[7:0],
                        s_sample_number[15:8]);
            end
            hist_sample[ch] = s_sample_number; sample_known[ch] = 1;
        end
        if (mask[5])
            add_cmd(5, crde_pkg::OP_OFFSET, s_sample_offset[7:0], s_sample_offset[15:8],
                    s_sample_offset[23:16], s_sample_offset[31:24]);
        for (int i = 1; i < cmd_list.size(); i++) begin
            tmp = cmd_list[i];
            for (int j = i - 1; j >= 0 && cmd_list[j].b[0] > tmp.b[0]; j--) begin
                cmd_list[j + 1] = cmd_list[j];
                cmd_list[j] = tmp;
            end
        end
        n = 0;
        foreach (cmd_list[i]) begin
            for (int j = 0; j < cmd_list[i].len && n < 18; j++) begin
                cb.data = cmd_list[i].b[j];
                cb.start = (j == 0);
                cb.last = 0;
                byte_queue.insert(byte_queue.size(), cb);
                n++;
            end
        end
        if (n > 0) byte_queue[byte_queue.size() - 1].last = 1;
    endtask

    always @(posedge aclk) begin
        cmd_byte_t want;
        if (!aresetn) begin
            fail_count = 0;
            byte_queue.delete();
            chan_count = crde_pkg::CNT_RESET;
            for (int i = 0; i < crde_pkg::CHANNELS; i++) begin
                hist_pitch[i] = 0; hist_vol_l[i] = 0; hist_vol_r[i] = 0;
                hist_sample[i] = 0; sample_known[i] = 1;
                hist_echo[i] = 0; echo_known[i] = 1;
                force_pitch[i] = 0; force_vol[i] = 0;
            end
        end else begin
            if (m_valid && m_ready) begin
                if (byte_queue.size() == 0) begin
                    report_mismatch("unexpected byte", m_cmd_byte, 0);
                end else begin
                    want = byte_queue.pop_front();
                    if (m_cmd_byte !== want.data) report_mismatch("cmd_byte", m_cmd_byte, want.data);
                    if (m_cmd_start !== want.start)
                        report_mismatch("cmd_start", m_cmd_start, want.start);
                    if (m_last_byte !== want.last)
                        report_mismatch("last_byte", m_last_byte, want.last);
                end
            end
            if (s_valid && s_ready) encode_word();
            if (cfg_we) chan_count = cfg_wdata;
        end
    end
endmodule

// ===== tb/sv/tb_channel_register_delta_encoder.sv =====
`timescale 1ns / 100ps

module tb_channel_register_delta_encoder;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [4:0]  cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [3:0]  s_channel = 0;
    logic        s_invalidate = 0;
    logic [5:0]  s_update_mask = 0;
    logic [15:0] s_pitch = 0;
    logic [7:0]  s_echo = 0;
    logic [15:0] s_vol_left = 0;
    logic [15:0] s_vol_right = 0;
    logic [15:0] s_sample_number = 0;
    logic [31:0] s_sample_offset = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [7:0]  m_cmd_byte;
    logic        m_cmd_start;
    logic        m_last_byte;
    int          fail_count;
    int          pending_bytes;
    int          cycle_count = 0;
    logic        hold_off = 0;
    logic        stim_done = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    channel_register_delta_encoder DUT (.*);

    crde_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge aclk) begin
        int phase;
        phase = cycle_count % 97;
        if (hold_off) m_ready <= 0;
        else if (phase < 30) m_ready <= 1;
        else if (phase < 60) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= 1'($urandom_range(0, 1));
    end

    task automatic send_word(logic [3:0] ch, logic inv, logic [5:0] mask, logic [15:0] pt,
                             logic [7:0] ec, logic [15:0] vl, logic [15:0] vr,
                             logic [15:0] smp, logic [31:0] off);
        s_valid <= 1;
        s_channel <= ch; s_invalidate <= inv; s_update_mask <= mask;
        s_pitch <= pt; s_echo <= ec; s_vol_left <= vl; s_vol_right <= vr;
        s_sample_number <= smp; s_sample_offset <= off;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap(int n);
        s_valid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain_all();
        s_valid <= 0;
        do @(posedge aclk); while (pending_bytes != 0);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_count(logic [4:0] v);
        drain_all();
        cfg_we <= 1; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // small deltas of either sign most of the time, full range otherwise
    function automatic logic [15:0] near(logic [15:0] v, int spread);
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return v + 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic random_words(int n, int ch_hi);
        logic [15:0] pt, vl, vr, smp;
        int burst;
        pt = 16'($urandom); vl = 16'($urandom); vr = 16'($urandom);
        smp = 16'($urandom_range(0, 3));
        burst = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            pt = near(pt, 300);
            vl = ($urandom_range(0, 9) == 0) ? 16'd0 : near(vl, 12);
            vr = ($urandom_range(0, 4) == 0) ? vl : near(vr, 12);
            if ($urandom_range(0, 2) == 0) smp = 16'($urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0) smp = 16'($urandom);
            send_word(4'($urandom_range(0, ch_hi)), $urandom_range(0, 9) == 0,
                      6'($urandom),
                      pt, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1)),
                      vl, vr, smp, $urandom);
            if (--burst == 0) begin
                idle_gap($urandom_range(1, 20));
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed words
        send_word(0, 0, 6'h01, 16'h0005, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h01, 16'h0000, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h01, 16'h0520, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h01, 16'h0590, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h01, 16'hffff, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h01, 16'h0000, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h01, 16'h0000, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h01, 16'h7f00, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h02, 0, 8'hff, 0, 0, 0, 0);
        send_word(0, 0, 6'h0c, 0, 0, 16'd5, 16'd5, 0, 0);
        send_word(0, 0, 6'h0c, 0, 0, 16'd60, 16'd60, 0, 0);
        send_word(0, 0, 6'h0c, 0, 0, 16'd63, 16'd57, 0, 0);
        send_word(0, 0, 6'h0c, 0, 0, 16'd163, 16'd20, 0, 0);
        send_word(0, 0, 6'h04, 0, 0, 16'hffff, 0, 0, 0);
        send_word(0, 0, 6'h0c, 0, 0, 16'd0, 16'd0, 0, 0);
        send_word(0, 0, 6'h10, 0, 0, 0, 0, 16'd0, 0);
        send_word(0, 0, 6'h10, 0, 0, 0, 0, 16'hffff, 0);
        send_word(0, 0, 6'h30, 0, 0, 0, 0, 16'hffff, 32'hffffffff);
        send_word(0, 1, 6'h00, 0, 0, 0, 0, 0, 0);
        send_word(0, 0, 6'h3f, 16'h1234, 8'h00, 16'h0001, 16'h0002, 16'h0000, 32'h89abcdef);
        send_word(1, 1, 6'h3f, 16'hffff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff);
        send_word(15, 0, 6'h3f, 16'h0001, 8'h01, 16'h0000, 16'h0008, 16'h0001, 32'h0);
        // receiver held off while words keep coming
        hold_off <= 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off <= 0;
            end
            random_words(12, 15);
        join
        write_count(5'd1);
        random_words(15, 15);
        write_count(5'd0);
        random_words(6, 15);
        write_count(5'd7);
        random_words(35, 15);
        write_count(5'd16);
        random_words(60, 3);
        drain_all();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
